// ===== rtl/core/lsfp_pkg.sv =====
// Shared constants, state encodings and control structs for the lidar scan frame parser.
`timescale 1ns / 1ps

package lsfp_pkg;

  // Frame layout, in bytes per field.
  localparam int HEADER_BYTES  = 2;
  localparam int CONTROL_BYTES = 1;
  localparam int ANGLE_BYTES   = 2;
  localparam int CHECK_BYTES   = 2;

  // One full turn in degrees times 64.
  localparam int FULL_TURN = 360 * 64;

  localparam int BYTE_W     = 8;
  localparam int ANG_W      = 15;
  localparam int DIST_W     = 14;
  localparam int IDX_W      = 8;
  localparam int LOW_W      = 6;
  localparam int HDR_WORD_W = 16;
  localparam logic [HDR_WORD_W-1:0] HDR_WORD_RESET = 16'h55AA;

  // Header window and its fill count.
  localparam int HDR_W     = BYTE_W * HEADER_BYTES;
  localparam int HDR_CMP_W = (HDR_W > HDR_WORD_W) ? HDR_W : HDR_WORD_W;
  localparam int FILL_W    = $clog2(HEADER_BYTES + 1);

  // Angle assembly.
  localparam int ACC_W  = BYTE_W * ANGLE_BYTES;
  localparam int HALF_W = ACC_W - 1;
  localparam int POS_W  = 2;

  // Byte counter within a field; must hold the largest field length.
  localparam int FCNT_W = 3;

  // Positions of the low and high distance bytes within a point.
  localparam int PT_LOW_POS  = 1;
  localparam int PT_HIGH_POS = 2;

  // Interpolation: product of sweep and index, then a restoring divide.
  localparam int PROD_W    = ANG_W + IDX_W;
  localparam int DIV_STEPS = ANG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  // Result stream packing.
  localparam int RES_W     = ANG_W + DIST_W + IDX_W;
  localparam int TDATA_W   = ((RES_W + 7) / 8) * 8;
  localparam int PAD_W     = TDATA_W - RES_W;

  typedef enum logic [6:0] {
    PH_HUNT   = 7'b0000001,
    PH_CTRL   = 7'b0000010,
    PH_COUNT  = 7'b0000100,
    PH_START  = 7'b0001000,
    PH_END    = 7'b0010000,
    PH_CHECK  = 7'b0100000,
    PH_POINTS = 7'b1000000
  } lsfp_phase_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_DIV   = 5'b00100,
    S_ADJ   = 5'b01000,
    S_WRITE = 5'b10000
  } lsfp_seq_t;

  typedef struct packed {
    logic             hdr_shift;
    logic             hdr_clear;
    logic             count_load;
    logic             acc_write;
    logic             acc_clear;
    logic             start_load;
    logic             end_load;
    logic             low_load;
    logic             point_capture;
    logic             point_clear;
    logic             reject_capture;
    logic             mul;
    logic             div_step;
    logic             adj;
    logic             out_load;
    logic [POS_W-1:0] byte_pos;
  } lsfp_cmd_t;

  typedef struct packed {
    logic hdr_match;
    logic count_zero;
    logic start_ok;
    logic end_ok;
    logic angle_ok_now;
    logic last_point;
    logic out_free;
  } lsfp_status_t;

endpackage

// ===== rtl/core/lsfp_ctrl.sv =====
// Controller: frame parse phases and the interpolation sequencer.
`timescale 1ns / 1ps

module lsfp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  lsfp_pkg::lsfp_status_t st,
  output lsfp_pkg::lsfp_cmd_t    cmd
);

  lsfp_pkg::lsfp_phase_t             phase, phase_next;
  lsfp_pkg::lsfp_seq_t               seq, seq_next;
  logic [lsfp_pkg::FCNT_W-1:0]       fcnt, fcnt_next;
  logic [lsfp_pkg::FCNT_W-1:0]       fcnt_inc;
  logic [lsfp_pkg::STEP_W-1:0]       step, step_next;
  logic                              in_fire;
  logic                              finish_now;
  logic                              finish_reject;
  logic                              reject_end;
  logic                              reject_chk;

  assign s_tready = (seq == lsfp_pkg::S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign fcnt_inc = fcnt + lsfp_pkg::FCNT_W'(1);

  // A frame is dropped on a zero count or an invalid angle. Without a
  // checksum field the end angle is judged on the byte that completes it.
  assign reject_end = st.count_zero || !st.start_ok || !st.angle_ok_now;
  assign reject_chk = st.count_zero || !st.start_ok || !st.end_ok;

  always_comb begin
    phase_next    = phase;
    seq_next      = seq;
    fcnt_next     = fcnt;
    step_next     = step;
    finish_now    = 1'b0;
    finish_reject = 1'b0;
    cmd           = '0;
    cmd.byte_pos  = fcnt[lsfp_pkg::POS_W-1:0];

    unique case (seq)
      lsfp_pkg::S_IDLE: begin
      end
      lsfp_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        step_next = '0;
        seq_next  = lsfp_pkg::S_DIV;
      end
      lsfp_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == lsfp_pkg::STEP_W'(lsfp_pkg::DIV_STEPS - 1)) begin
          step_next = '0;
          seq_next  = lsfp_pkg::S_ADJ;
        end else begin
          step_next = step + lsfp_pkg::STEP_W'(1);
        end
      end
      lsfp_pkg::S_ADJ: begin
        cmd.adj  = 1'b1;
        seq_next = lsfp_pkg::S_WRITE;
      end
      lsfp_pkg::S_WRITE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          seq_next     = lsfp_pkg::S_IDLE;
        end
      end
      default: begin
        seq_next = lsfp_pkg::S_IDLE;
      end
    endcase

    if (in_fire) begin
      unique case (phase)
        lsfp_pkg::PH_HUNT: begin
          cmd.hdr_shift = 1'b1;
          if (st.hdr_match) begin
            phase_next = lsfp_pkg::PH_CTRL;
            fcnt_next  = '0;
          end
        end
        lsfp_pkg::PH_CTRL: begin
          if (fcnt_inc >= lsfp_pkg::FCNT_W'(lsfp_pkg::CONTROL_BYTES)) begin
            phase_next = lsfp_pkg::PH_COUNT;
            fcnt_next  = '0;
          end else begin
            fcnt_next = fcnt_inc;
          end
        end
        lsfp_pkg::PH_COUNT: begin
          cmd.count_load = 1'b1;
          cmd.acc_clear  = 1'b1;
          phase_next     = lsfp_pkg::PH_START;
          fcnt_next      = '0;
        end
        lsfp_pkg::PH_START: begin
          cmd.acc_write = 1'b1;
          if (fcnt_inc < lsfp_pkg::FCNT_W'(lsfp_pkg::ANGLE_BYTES)) begin
            fcnt_next = fcnt_inc;
          end else begin
            fcnt_next      = '0;
            cmd.start_load = 1'b1;
            cmd.acc_clear  = 1'b1;
            phase_next     = lsfp_pkg::PH_END;
          end
        end
        lsfp_pkg::PH_END: begin
          cmd.acc_write = 1'b1;
          if (fcnt_inc < lsfp_pkg::FCNT_W'(lsfp_pkg::ANGLE_BYTES)) begin
            fcnt_next = fcnt_inc;
          end else begin
            fcnt_next     = '0;
            cmd.end_load  = 1'b1;
            cmd.acc_clear = 1'b1;
            if (lsfp_pkg::CHECK_BYTES == 0) begin
              finish_now    = 1'b1;
              finish_reject = reject_end;
            end else begin
              phase_next = lsfp_pkg::PH_CHECK;
            end
          end
        end
        lsfp_pkg::PH_CHECK: begin
          if (fcnt_inc >= lsfp_pkg::FCNT_W'(lsfp_pkg::CHECK_BYTES)) begin
            fcnt_next     = '0;
            finish_now    = 1'b1;
            finish_reject = reject_chk;
          end else begin
            fcnt_next = fcnt_inc;
          end
        end
        lsfp_pkg::PH_POINTS: begin
          if (fcnt == '0) begin
            fcnt_next = lsfp_pkg::FCNT_W'(lsfp_pkg::PT_LOW_POS);
          end else if (fcnt == lsfp_pkg::FCNT_W'(lsfp_pkg::PT_LOW_POS)) begin
            cmd.low_load = 1'b1;
            fcnt_next    = lsfp_pkg::FCNT_W'(lsfp_pkg::PT_HIGH_POS);
          end else begin
            cmd.point_capture = 1'b1;
            fcnt_next         = '0;
            seq_next          = lsfp_pkg::S_MUL;
            if (st.last_point) begin
              phase_next    = lsfp_pkg::PH_HUNT;
              cmd.hdr_clear = 1'b1;
            end
          end
        end
        default: begin
          phase_next    = lsfp_pkg::PH_HUNT;
          fcnt_next     = '0;
          cmd.hdr_clear = 1'b1;
        end
      endcase

      if (finish_now) begin
        if (finish_reject) begin
          cmd.reject_capture = 1'b1;
          cmd.hdr_clear      = 1'b1;
          phase_next         = lsfp_pkg::PH_HUNT;
          seq_next           = lsfp_pkg::S_WRITE;
        end else begin
          cmd.point_clear = 1'b1;
          phase_next      = lsfp_pkg::PH_POINTS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= lsfp_pkg::PH_HUNT;
      seq   <= lsfp_pkg::S_IDLE;
      fcnt  <= '0;
      step  <= '0;
    end else begin
      phase <= phase_next;
      seq   <= seq_next;
      fcnt  <= fcnt_next;
      step  <= step_next;
    end
  end

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (seq == lsfp_pkg::S_DIV) |-> (step < lsfp_pkg::STEP_W'(lsfp_pkg::DIV_STEPS)))
    else $error("divide step count out of range");

  a_point_starts_calc: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (phase == lsfp_pkg::PH_POINTS) &&
     (fcnt == lsfp_pkg::FCNT_W'(lsfp_pkg::PT_HIGH_POS)))
    |=> (seq == lsfp_pkg::S_MUL))
    else $error("high distance byte did not start the angle calculation");

  a_mul_then_div: assert property (@(posedge clk) disable iff (rst)
    (seq == lsfp_pkg::S_MUL) |=> ((seq == lsfp_pkg::S_DIV) && (step == '0)))
    else $error("divide did not start cleanly after the multiply");

  a_last_rehunts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (phase == lsfp_pkg::PH_POINTS) && st.last_point &&
     (fcnt == lsfp_pkg::FCNT_W'(lsfp_pkg::PT_HIGH_POS)))
    |=> (phase == lsfp_pkg::PH_HUNT))
    else $error("parser did not return to header hunt after the last point");

endmodule

// ===== rtl/core/lsfp_dp.sv =====
// Datapath: header window, angle decode, interpolation arithmetic and result register.
`timescale 1ns / 1ps

module lsfp_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [lsfp_pkg::BYTE_W-1:0]           data_byte,
  input  logic                                  cfg_fire,
  input  logic [lsfp_pkg::HDR_WORD_W-1:0]       cfg_data,
  input  lsfp_pkg::lsfp_cmd_t                   cmd,
  output lsfp_pkg::lsfp_status_t                st,
  input  logic                                  m_tready,
  output logic                                  m_tvalid,
  output logic [lsfp_pkg::TDATA_W-1:0]          m_tdata,
  output logic                                  m_tlast,
  output logic                                  m_tuser
);

  // Configuration and header hunt.
  logic [lsfp_pkg::HDR_WORD_W-1:0]        hdr_word;
  logic [lsfp_pkg::HDR_W-1:0]             window;
  logic [lsfp_pkg::HDR_W+lsfp_pkg::BYTE_W-1:0] window_cat;
  logic [lsfp_pkg::HDR_W-1:0]             window_next;
  logic [lsfp_pkg::FILL_W-1:0]            fill, fill_next;

  // Frame header fields.
  logic [lsfp_pkg::IDX_W-1:0]             count;
  logic [lsfp_pkg::ACC_W-1:0]             acc;
  logic [lsfp_pkg::ACC_W-1:0]             raw;
  logic [lsfp_pkg::HALF_W-1:0]            half;
  logic                                   ang_ok;
  logic [lsfp_pkg::ANG_W-1:0]             ang_val;
  logic [lsfp_pkg::ANG_W-1:0]             start_ang, end_ang;
  logic                                   start_ok, end_ok;

  // Point state and captured result.
  logic [lsfp_pkg::IDX_W-1:0]             cur_pt;
  logic [lsfp_pkg::LOW_W-1:0]             low_bits;
  logic                                   last_now;
  logic [lsfp_pkg::IDX_W-1:0]             idx_w;
  logic [lsfp_pkg::DIST_W-1:0]            dist_w;
  logic                                   last_w;
  logic                                   rej_w;

  // Interpolation arithmetic.
  logic [lsfp_pkg::ANG_W:0]               cw_wide;
  logic [lsfp_pkg::ANG_W-1:0]             cw;
  logic [lsfp_pkg::PROD_W-1:0]            prod;
  logic [lsfp_pkg::IDX_W-1:0]             divisor;
  logic [lsfp_pkg::IDX_W-1:0]             rem;
  logic [lsfp_pkg::ANG_W-1:0]             quo_sh;
  logic [lsfp_pkg::IDX_W:0]               trial, diff;
  logic                                   ge;
  logic [lsfp_pkg::ANG_W-1:0]             quo;
  logic [lsfp_pkg::ANG_W:0]               sum, sum_wrap;
  logic [lsfp_pkg::ANG_W-1:0]             ang_res;

  // Output register.
  logic                                   out_valid;
  logic [lsfp_pkg::ANG_W-1:0]             out_ang;
  logic [lsfp_pkg::DIST_W-1:0]            out_dist;
  logic [lsfp_pkg::IDX_W-1:0]             out_idx;
  logic                                   out_last;
  logic                                   out_rej;

  // Little-endian window: the newest byte enters at the top.
  assign window_cat  = {data_byte, window};
  assign window_next = window_cat[lsfp_pkg::HDR_W+lsfp_pkg::BYTE_W-1:lsfp_pkg::BYTE_W];
  assign fill_next   = (fill < lsfp_pkg::FILL_W'(lsfp_pkg::HEADER_BYTES)) ?
                       fill + lsfp_pkg::FILL_W'(1) : fill;

  always_comb begin
    raw = acc;
    for (int i = 0; i < lsfp_pkg::ANGLE_BYTES; i++) begin
      if (cmd.byte_pos == lsfp_pkg::POS_W'(i)) begin
        raw[lsfp_pkg::BYTE_W*i +: lsfp_pkg::BYTE_W] = data_byte;
      end
    end
  end

  // Bit 0 is a check bit; a full turn exactly wraps to zero.
  assign half    = raw[lsfp_pkg::ACC_W-1:1];
  assign ang_ok  = raw[0] && (half <= lsfp_pkg::HALF_W'(lsfp_pkg::FULL_TURN));
  assign ang_val = (!ang_ok || (half == lsfp_pkg::HALF_W'(lsfp_pkg::FULL_TURN))) ?
                   '0 : half[lsfp_pkg::ANG_W-1:0];

  assign last_now = ({1'b0, cur_pt} + (lsfp_pkg::IDX_W+1)'(1)) >= {1'b0, count};

  // Clockwise sweep from start to end.
  assign cw_wide = (end_ang >= start_ang) ?
                   ({1'b0, end_ang} - {1'b0, start_ang}) :
                   ({1'b0, end_ang} + (lsfp_pkg::ANG_W+1)'(lsfp_pkg::FULL_TURN)
                    - {1'b0, start_ang});
  assign cw      = cw_wide[lsfp_pkg::ANG_W-1:0];
  assign prod    = lsfp_pkg::PROD_W'(cw) * lsfp_pkg::PROD_W'(idx_w);
  assign divisor = count - lsfp_pkg::IDX_W'(1);

  // One restoring step per cycle; the quotient shifts in behind the dividend.
  assign trial = {rem, quo_sh[lsfp_pkg::ANG_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  assign quo      = (count == lsfp_pkg::IDX_W'(1)) ? '0 : quo_sh;
  assign sum      = {1'b0, start_ang} + {1'b0, quo};
  assign sum_wrap = sum - (lsfp_pkg::ANG_W+1)'(lsfp_pkg::FULL_TURN);

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_word  <= lsfp_pkg::HDR_WORD_RESET;
      window    <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_fire) begin
        hdr_word <= cfg_data;
      end
      if (cmd.hdr_clear) begin
        window <= '0;
        fill   <= '0;
      end else if (cmd.hdr_shift) begin
        window <= window_next;
        fill   <= fill_next;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.count_load) begin
      count <= data_byte;
    end
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (cmd.acc_write) begin
      acc <= raw;
    end
    if (cmd.start_load) begin
      start_ang <= ang_val;
      start_ok  <= ang_ok;
    end
    if (cmd.end_load) begin
      end_ang <= ang_val;
      end_ok  <= ang_ok;
    end
    if (cmd.low_load) begin
      low_bits <= data_byte[lsfp_pkg::BYTE_W-1:2];
    end
    if (cmd.point_clear) begin
      cur_pt <= '0;
    end else if (cmd.point_capture) begin
      cur_pt <= cur_pt + lsfp_pkg::IDX_W'(1);
    end
    if (cmd.point_capture) begin
      idx_w  <= cur_pt;
      last_w <= last_now;
      dist_w <= {data_byte, low_bits};
      rej_w  <= 1'b0;
    end else if (cmd.reject_capture) begin
      idx_w   <= '0;
      last_w  <= 1'b0;
      dist_w  <= '0;
      rej_w   <= 1'b1;
    end
    if (cmd.reject_capture) begin
      ang_res <= '0;
    end else if (cmd.adj) begin
      ang_res <= (sum >= (lsfp_pkg::ANG_W+1)'(lsfp_pkg::FULL_TURN)) ?
                 sum_wrap[lsfp_pkg::ANG_W-1:0] : sum[lsfp_pkg::ANG_W-1:0];
    end
    if (cmd.mul) begin
      rem    <= prod[lsfp_pkg::PROD_W-1:lsfp_pkg::ANG_W];
      quo_sh <= prod[lsfp_pkg::ANG_W-1:0];
    end else if (cmd.div_step) begin
      rem    <= ge ? diff[lsfp_pkg::IDX_W-1:0] : trial[lsfp_pkg::IDX_W-1:0];
      quo_sh <= {quo_sh[lsfp_pkg::ANG_W-2:0], ge};
    end
    if (cmd.out_load) begin
      out_ang  <= ang_res;
      out_dist <= dist_w;
      out_idx  <= idx_w;
      out_last <= last_w;
      out_rej  <= rej_w;
    end
  end

  assign st.hdr_match    = (fill_next == lsfp_pkg::FILL_W'(lsfp_pkg::HEADER_BYTES)) &&
                           (lsfp_pkg::HDR_CMP_W'(window_next) ==
                            lsfp_pkg::HDR_CMP_W'(hdr_word));
  assign st.count_zero   = (count == '0);
  assign st.start_ok     = start_ok;
  assign st.end_ok       = end_ok;
  assign st.angle_ok_now = ang_ok;
  assign st.last_point   = last_now;
  assign st.out_free     = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{lsfp_pkg::PAD_W{1'b0}}, out_idx, out_dist, out_ang};
  assign m_tlast  = out_last;
  assign m_tuser  = out_rej;

endmodule

// ===== rtl/core/lidar_scan_frame_parser.sv =====
// Top level of the lidar scan frame parser: byte stream in, point results out.
`timescale 1ns / 1ps

// The slave stream takes one raw byte of the lidar serial link per transaction.
// The parser slides a window over the incoming bytes until the little-endian
// header matches header_word, skips the control bytes, reads the point count,
// the start and end angles and the checksum bytes, then decodes three bytes per
// point: intensity (dropped), low and high distance bytes.
// Each point gives one master transaction with its distance and an angle
// interpolated clockwise between start and end; tlast marks the last point of
// the frame. A zero count or an invalid angle gives one transaction with tuser
// set and all other fields zero, and the hunt for a header starts again.
// Bytes that produce no result are taken at one per cycle while the sequencer
// is idle. The high distance byte of a point starts the interpolation: a
// multiply, a restoring divide by count minus one, a wrap step and a load into
// the output register, which waits until that register is free; tready stays
// low from that byte until the load. After the last checksum byte a rejection
// goes through the sequencer's write state into the output register.
// A single output register holds the result; while it waits for the receiver,
// bytes that produce no result are still taken, and the next result waits in
// the sequencer until the register frees up. Reset (rst, synchronous) returns
// to header hunting with an empty window and header_word back to 0x55AA.
// The configuration channel is always ready and should be written when idle.

module lidar_scan_frame_parser (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input byte stream. tdata: data_byte[7:0].
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [lsfp_pkg::BYTE_W-1:0]          s_tdata,
  // Result stream. tdata: point_angle[14:0], point_distance[28:15],
  // point_index[36:29], zero fill above. tlast: last_point.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [lsfp_pkg::TDATA_W-1:0]         m_tdata,
  output logic                                 m_tlast,
  // tuser: frame_rejected[0].
  output logic                                 m_tuser,
  // Header word write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lsfp_pkg::HDR_WORD_W-1:0]      cfg_data
);

  lsfp_pkg::lsfp_cmd_t    cmd;
  lsfp_pkg::lsfp_status_t st;
  logic                   cfg_fire;

  // The header register can take a write in any cycle.
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  lsfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lsfp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (s_tdata),
    .cfg_fire  (cfg_fire),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
